[hw/rtl/fvdc_pkg.sv]
// ---------------------------------------------------------------------------
// fvdc_pkg
// Shared types and constants for the five-point diffusion coefficient block.
// ---------------------------------------------------------------------------
package fvdc_pkg;

    localparam int FVDC_FRAC_BITS = 16;

    // Width of the center coefficient sum before saturation.
    localparam int AP_W = 36;

    localparam logic [1:0] COL_LEFT   = 2'd1;
    localparam logic [1:0] COL_RIGHT  = 2'd2;
    localparam logic [1:0] ROW_BOTTOM = 2'd1;
    localparam logic [1:0] ROW_TOP    = 2'd2;

    typedef enum logic [2:0] {
        CFG_RATIO_DY_DX = 3'd0,
        CFG_RATIO_DX_DY = 3'd1,
        CFG_SINK        = 3'd2,
        CFG_WALL_LEFT   = 3'd3,
        CFG_WALL_RIGHT  = 3'd4,
        CFG_WALL_TOP    = 3'd5,
        CFG_BOTTOM_FLUX = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]         col_class;
        logic [1:0]         row_class;
        logic [30:0]        k_center;
        logic [30:0]        k_east;
        logic [30:0]        k_west;
        logic [30:0]        k_north;
        logic [30:0]        k_south;
        logic signed [31:0] source_in;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] coef_center;
        logic signed [31:0] coef_east;
        logic signed [31:0] coef_west;
        logic signed [31:0] coef_north;
        logic signed [31:0] coef_south;
        logic signed [31:0] rhs_out;
    } out_item_t;

    // Load enables for the first three pipeline stages.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } pipe_ld_t;

endpackage

[hw/rtl/fvdc_face.sv]
// ---------------------------------------------------------------------------
// fvdc_face
// Three-stage face coefficient: mean diffusivity, product with the spacing
// ratio, then scaling and saturation to 31 bits, or zero at a wall.
// ---------------------------------------------------------------------------
module fvdc_face
    import fvdc_pkg::*;
#(
    parameter int FRAC_BITS = FVDC_FRAC_BITS
)
(
    input  logic        clk,
    input  pipe_ld_t    ld,
    input  logic [30:0] ka,
    input  logic [30:0] kb,
    input  logic [30:0] ratio,
    input  logic        at_wall,
    output logic [30:0] coef
);

    logic [31:0] sum_ab;
    logic [30:0] mean_reg;
    logic [30:0] mean_next;
    logic [61:0] prod_reg;
    logic [61:0] prod_next;
    logic [61:0] scaled;
    logic [30:0] coef_reg;
    logic [30:0] coef_next;
    logic        wall_s1_reg;
    logic        wall_s2_reg;

    assign sum_ab    = {1'b0, ka} + {1'b0, kb};
    assign mean_next = sum_ab[31:1];
    assign prod_next = mean_reg * ratio;
    assign scaled    = prod_reg >> FRAC_BITS;

    always_comb
    begin
        if (wall_s2_reg)
        begin
            coef_next = '0;
        end
        else if (|scaled[61:31])
        begin
            coef_next = '1;
        end
        else
        begin
            coef_next = scaled[30:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.ld1)
        begin
            mean_reg    <= mean_next;
            wall_s1_reg <= at_wall;
        end
        if (ld.ld2)
        begin
            prod_reg    <= prod_next;
            wall_s2_reg <= wall_s1_reg;
        end
        if (ld.ld3)
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

[hw/rtl/fv_diffusion_coeffs_top.sv]
// ---------------------------------------------------------------------------
// fv_diffusion_coeffs_top
// Five-point finite-volume diffusion coefficients for one grid cell per item.
// ---------------------------------------------------------------------------
// The block takes one cell item per clock cycle while in_ready is high and
// returns one result item for each, in order. The work runs through five
// register stages: face means, the six multiplications, scaling and
// saturation, partial sums, and the final sums with saturation, whose register
// drives the output. in_ready drops only when all five stages hold items and
// the output is stalled. Configuration writes are taken in any cycle
// (cfg_ready is always high) and must only be made while the block is idle.
module fv_diffusion_coeffs_top
    import fvdc_pkg::*;
#(
    parameter int FRAC_BITS = FVDC_FRAC_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int          TW        = 65 - FRAC_BITS;
    localparam int          RW        = ((TW + 1 > 33) ? TW + 1 : 33) + 1;
    localparam logic [30:0] RATIO_ONE = 31'(1) << FRAC_BITS;

    // Configuration registers.
    logic [30:0]        ratio_x_reg;
    logic [30:0]        ratio_y_reg;
    logic signed [31:0] sink_reg;
    logic signed [31:0] wall_left_reg;
    logic signed [31:0] wall_right_reg;
    logic signed [31:0] wall_top_reg;
    logic signed [31:0] bottom_flux_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_x_reg     <= RATIO_ONE;
            ratio_y_reg     <= RATIO_ONE;
            sink_reg        <= '0;
            wall_left_reg   <= '0;
            wall_right_reg  <= '0;
            wall_top_reg    <= '0;
            bottom_flux_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_RATIO_DY_DX: ratio_x_reg     <= cfg_data[30:0];
                CFG_RATIO_DX_DY: ratio_y_reg     <= cfg_data[30:0];
                CFG_SINK:        sink_reg        <= cfg_data;
                CFG_WALL_LEFT:   wall_left_reg   <= cfg_data;
                CFG_WALL_RIGHT:  wall_right_reg  <= cfg_data;
                CFG_WALL_TOP:    wall_top_reg    <= cfg_data;
                CFG_BOTTOM_FLUX: bottom_flux_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Pipeline flow control: a stage loads when it is empty or its item moves on.
    logic [5:1] v_reg;
    logic [5:1] v_next;
    logic [5:0] vin;
    logic [5:1] rdy;
    logic [5:1] ld;
    pipe_ld_t   face_ld;

    always_comb
    begin
        vin    = {v_reg, in_valid};
        rdy[5] = !v_reg[5] || out_ready;
        for (int k = 4; k >= 1; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k + 1];
        end
        for (int k = 1; k <= 5; k++)
        begin
            ld[k]     = rdy[k] && vin[k - 1];
            v_next[k] = rdy[k] ? vin[k - 1] : v_reg[k];
        end
    end

    assign in_ready  = rdy[1];
    assign out_valid = v_reg[5];
    assign face_ld   = '{ld1: ld[1], ld2: ld[2], ld3: ld[3]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // Cell class flags.
    logic in_left;
    logic in_right;
    logic in_bottom;
    logic in_top;

    assign in_left   = (in_item.col_class == COL_LEFT);
    assign in_right  = (in_item.col_class == COL_RIGHT);
    assign in_bottom = (in_item.row_class == ROW_BOTTOM);
    assign in_top    = (in_item.row_class == ROW_TOP);

    // Face units.
    logic [30:0] face_e;
    logic [30:0] face_w;
    logic [30:0] face_n;
    logic [30:0] face_s;

    fvdc_face #(.FRAC_BITS(FRAC_BITS)) u_face_e (
        .clk(clk), .ld(face_ld), .ka(in_item.k_center), .kb(in_item.k_east),
        .ratio(ratio_x_reg), .at_wall(in_right), .coef(face_e)
    );

    fvdc_face #(.FRAC_BITS(FRAC_BITS)) u_face_w (
        .clk(clk), .ld(face_ld), .ka(in_item.k_center), .kb(in_item.k_west),
        .ratio(ratio_x_reg), .at_wall(in_left), .coef(face_w)
    );

    fvdc_face #(.FRAC_BITS(FRAC_BITS)) u_face_n (
        .clk(clk), .ld(face_ld), .ka(in_item.k_center), .kb(in_item.k_north),
        .ratio(ratio_y_reg), .at_wall(in_top), .coef(face_n)
    );

    fvdc_face #(.FRAC_BITS(FRAC_BITS)) u_face_s (
        .clk(clk), .ld(face_ld), .ka(in_item.k_center), .kb(in_item.k_south),
        .ratio(ratio_y_reg), .at_wall(in_bottom), .coef(face_s)
    );

    // Stage 1: flags, source and the selected side wall value.
    logic               s1_xwall_reg;
    logic               s1_top_reg;
    logic               s1_bottom_reg;
    logic signed [31:0] s1_src_reg;
    logic signed [31:0] s1_wallx_reg;

    // Stage 2: wall products.
    logic               s2_xwall_reg;
    logic               s2_top_reg;
    logic               s2_bottom_reg;
    logic signed [31:0] s2_src_reg;
    logic signed [63:0] s2_px_reg;
    logic signed [63:0] s2_py_reg;
    logic signed [63:0] px_next;
    logic signed [63:0] py_next;

    // Stage 3: wall terms and wall coefficient sum.
    logic               s3_top_reg;
    logic               s3_bottom_reg;
    logic signed [31:0] s3_src_reg;
    logic signed [TW-1:0] s3_twx_reg;
    logic signed [TW-1:0] s3_twy_reg;
    logic [32:0]        s3_wcoef_reg;
    logic [32:0]        wcoef_next;

    // Stage 4: partial sums.
    logic [31:0]          s4_ap_a_reg;
    logic [31:0]          s4_ap_b_reg;
    logic signed [34:0]   s4_ap_c_reg;
    logic signed [32:0]   s4_rhs_a_reg;
    logic signed [TW:0]   s4_rhs_b_reg;
    logic [30:0]          s4_e_reg;
    logic [30:0]          s4_w_reg;
    logic [30:0]          s4_n_reg;
    logic [30:0]          s4_s_reg;

    // Stage 5: final sums and output register.
    logic signed [AP_W-1:0] ap_sum;
    logic signed [RW-1:0]   rhs_sum;
    logic signed [31:0]     ap_sat;
    logic signed [31:0]     rhs_sat;
    out_item_t              out_reg;

    assign px_next = $signed({1'b0, ratio_x_reg}) * s1_wallx_reg;
    assign py_next = $signed({1'b0, ratio_y_reg}) * wall_top_reg;

    // The wall coefficient is twice the ratio, so its term shifts by one less.
    always_comb
    begin
        wcoef_next = '0;
        if (s2_xwall_reg)
        begin
            wcoef_next = {2'b00, ratio_x_reg} << 1;
        end
        if (s2_top_reg)
        begin
            wcoef_next = wcoef_next + ({2'b00, ratio_y_reg} << 1);
        end
    end

    always_comb
    begin
        ap_sum  = AP_W'(signed'({1'b0, s4_ap_a_reg})) + AP_W'(signed'({1'b0, s4_ap_b_reg}))
                  + AP_W'(s4_ap_c_reg);
        rhs_sum = RW'(s4_rhs_a_reg) + RW'(s4_rhs_b_reg);

        if ((&ap_sum[AP_W-1:31]) || !(|ap_sum[AP_W-1:31]))
        begin
            ap_sat = ap_sum[31:0];
        end
        else
        begin
            ap_sat = ap_sum[AP_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end

        if ((&rhs_sum[RW-1:31]) || !(|rhs_sum[RW-1:31]))
        begin
            rhs_sat = rhs_sum[31:0];
        end
        else
        begin
            rhs_sat = rhs_sum[RW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            s1_xwall_reg  <= in_left || in_right;
            s1_top_reg    <= in_top;
            s1_bottom_reg <= in_bottom;
            s1_src_reg    <= in_item.source_in;
            s1_wallx_reg  <= in_left ? wall_left_reg : wall_right_reg;
        end
        if (ld[2])
        begin
            s2_xwall_reg  <= s1_xwall_reg;
            s2_top_reg    <= s1_top_reg;
            s2_bottom_reg <= s1_bottom_reg;
            s2_src_reg    <= s1_src_reg;
            s2_px_reg     <= px_next;
            s2_py_reg     <= py_next;
        end
        if (ld[3])
        begin
            s3_top_reg    <= s2_top_reg;
            s3_bottom_reg <= s2_bottom_reg;
            s3_src_reg    <= s2_src_reg;
            s3_twx_reg    <= s2_xwall_reg ? TW'(s2_px_reg >>> (FRAC_BITS - 1)) : '0;
            s3_twy_reg    <= s2_top_reg ? TW'(s2_py_reg >>> (FRAC_BITS - 1)) : '0;
            s3_wcoef_reg  <= wcoef_next;
        end
        if (ld[4])
        begin
            s4_ap_a_reg  <= {1'b0, face_e} + {1'b0, face_w};
            s4_ap_b_reg  <= {1'b0, face_n} + {1'b0, face_s};
            s4_ap_c_reg  <= $signed({2'b00, s3_wcoef_reg}) - 35'(sink_reg);
            s4_rhs_a_reg <= 33'(s3_src_reg)
                            + (s3_bottom_reg ? 33'(bottom_flux_reg) : 33'sd0);
            s4_rhs_b_reg <= (TW + 1)'(s3_twx_reg) + (TW + 1)'(s3_twy_reg);
            s4_e_reg     <= face_e;
            s4_w_reg     <= face_w;
            s4_n_reg     <= face_n;
            s4_s_reg     <= face_s;
        end
        if (ld[5])
        begin
            out_reg.coef_center <= ap_sat;
            out_reg.coef_east   <= {1'b0, s4_e_reg};
            out_reg.coef_west   <= {1'b0, s4_w_reg};
            out_reg.coef_north  <= {1'b0, s4_n_reg};
            out_reg.coef_south  <= {1'b0, s4_s_reg};
            out_reg.rhs_out     <= rhs_sat;
        end
    end

    assign out_item = out_reg;

    // An accepted item always lands in the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v_reg[1])
    else $error("accepted item did not enter stage one");

    // The input is only held off when every stage is full and the output stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> ((&v_reg) && !out_ready))
    else $error("input stalled with room in the pipeline");

    // A stalled result is never dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[5] && !out_ready) |=> v_reg[5])
    else $error("stalled result lost");

    // Face units stay aligned with the wall flags carried in the top level.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[3] && s3_top_reg) |-> (face_n == '0))
    else $error("north face not cleared on the top row");

endmodule

[sim/tb_fv_diffusion_coeffs_top.sv]
// ---------------------------------------------------------------------------
// tb_fv_diffusion_coeffs_top
// Streams grid cells through the diffusion coefficient block and checks every
// result item against a cycle-free predictor of the coefficient arithmetic.
// Directed cells cover each column and row class and the saturation limits;
// random phases vary register settings, input gaps and output stalls.
// ---------------------------------------------------------------------------
module tb_fv_diffusion_coeffs_top
    import fvdc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          FRAC          = FVDC_FRAC_BITS;
    localparam int          LATENCY       = 4;
    localparam int          SETTLE_CYCLES = 12;
    localparam int          HOLD_CYCLES   = 80;
    localparam int          MAX_REPORTS   = 10;
    localparam logic [30:0] K_MAX         = 31'h7FFF_FFFF;
    localparam logic [30:0] K_ONE         = 31'h0001_0000;
    localparam logic [2:0]  CFG_UNUSED    = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // Register copies used by the predictor.
    logic [30:0]        ew_ratio;
    logic [30:0]        ns_ratio;
    logic signed [31:0] sink_term;
    logic signed [31:0] left_wall;
    logic signed [31:0] right_wall;
    logic signed [31:0] top_wall;
    logic signed [31:0] bottom_flux;

    out_item_t expected_coeffs[$];
    int        error_count = 0;
    int        result_count = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;
    logic      hold_req = 1'b0;
    string     field_name[6] = '{"coef_center", "coef_east", "coef_west",
                                 "coef_north", "coef_south", "rhs_out"};

    fv_diffusion_coeffs_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic signed [63:0] face_coef(input logic [30:0] ka,
                                                     input logic [30:0] kb,
                                                     input logic [30:0] ratio);
        logic [31:0] k_sum;
        logic [61:0] prod;
        logic [61:0] scaled;
        k_sum  = {1'b0, ka} + {1'b0, kb};
        prod   = k_sum[31:1] * ratio;
        scaled = prod >> FRAC;
        if (scaled > 62'(K_MAX))
            return 64'sd2147483647;
        return $signed({2'b00, scaled});
    endfunction

    // Wall coefficient times wall value, floored back to the fixed point scale.
    function automatic logic signed [63:0] wall_term(input logic signed [33:0] wcoef,
                                                     input logic signed [31:0] wall);
        logic signed [79:0] prod;
        prod = wcoef * wall;
        return 64'(prod >>> FRAC);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic out_item_t cell_coeffs(input in_item_t c);
        out_item_t          r;
        logic               left, right, bottom, top;
        logic signed [33:0] wall_ew, wall_ns;
        logic signed [63:0] a_e, a_w, a_n, a_s, center, rhs;
        left    = (c.col_class == COL_LEFT);
        right   = (c.col_class == COL_RIGHT);
        bottom  = (c.row_class == ROW_BOTTOM);
        top     = (c.row_class == ROW_TOP);
        wall_ew = $signed({2'b00, ew_ratio, 1'b0});
        wall_ns = $signed({2'b00, ns_ratio, 1'b0});
        a_e = right  ? 64'sd0 : face_coef(c.k_center, c.k_east, ew_ratio);
        a_w = left   ? 64'sd0 : face_coef(c.k_center, c.k_west, ew_ratio);
        a_n = top    ? 64'sd0 : face_coef(c.k_center, c.k_north, ns_ratio);
        a_s = bottom ? 64'sd0 : face_coef(c.k_center, c.k_south, ns_ratio);
        center = a_e + a_w + a_n + a_s - sink_term;
        rhs    = $signed(c.source_in);
        if (left)
        begin
            center += wall_ew;
            rhs    += wall_term(wall_ew, left_wall);
        end
        if (right)
        begin
            center += wall_ew;
            rhs    += wall_term(wall_ew, right_wall);
        end
        if (top)
        begin
            center += wall_ns;
            rhs    += wall_term(wall_ns, top_wall);
        end
        if (bottom)
            rhs += bottom_flux;
        r.coef_center = sat32(center);
        r.coef_east   = a_e[31:0];
        r.coef_west   = a_w[31:0];
        r.coef_north  = a_n[31:0];
        r.coef_south  = a_s[31:0];
        r.rhs_out     = sat32(rhs);
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return $urandom_range(1 << 21) - (1 << 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_ratio();
        case ($urandom_range(5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom_range(1 << 18);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_k();
        case ($urandom_range(7))
            0: return '0;
            1: return K_MAX;
            2: return K_MAX - 31'($urandom_range(255));
            3, 4, 5: return 31'($urandom_range(1 << 20));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic in_item_t random_cell();
        in_item_t c;
        c.col_class = 2'($urandom_range(3));
        c.row_class = 2'($urandom_range(3));
        c.k_center  = rand_k();
        c.k_east    = rand_k();
        c.k_west    = rand_k();
        c.k_north   = rand_k();
        c.k_south   = rand_k();
        c.source_in = rand_word();
        return c;
    endfunction

    function automatic in_item_t make_cell(input logic [1:0] cc, input logic [1:0] rc,
                                           input logic [30:0] kc, input logic [30:0] ke,
                                           input logic [30:0] kw, input logic [30:0] kn,
                                           input logic [30:0] ks, input logic [31:0] src);
        in_item_t c;
        c = '{cc, rc, kc, ke, kw, kn, ks, src};
        return c;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_RATIO_DY_DX: ew_ratio    = data[30:0];
            CFG_RATIO_DX_DY: ns_ratio    = data[30:0];
            CFG_SINK:        sink_term   = data;
            CFG_WALL_LEFT:   left_wall   = data;
            CFG_WALL_RIGHT:  right_wall  = data;
            CFG_WALL_TOP:    top_wall    = data;
            CFG_BOTTOM_FLUX: bottom_flux = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_config(input logic [31:0] r_ew, input logic [31:0] r_ns,
                               input logic [31:0] sink, input logic [31:0] w_l,
                               input logic [31:0] w_r, input logic [31:0] w_t,
                               input logic [31:0] flux);
        write_reg(CFG_RATIO_DY_DX, r_ew);
        write_reg(CFG_RATIO_DX_DY, r_ns);
        write_reg(CFG_SINK, sink);
        write_reg(CFG_WALL_LEFT, w_l);
        write_reg(CFG_WALL_RIGHT, w_r);
        write_reg(CFG_WALL_TOP, w_t);
        write_reg(CFG_BOTTOM_FLUX, flux);
    endtask

    task automatic random_config();
        load_config(rand_ratio(), rand_ratio(), rand_word(), rand_word(),
                    rand_word(), rand_word(), rand_word());
    endtask

    // The sender idles cycle by cycle with probability idle_pct before each item.
    task automatic send_cell(input in_item_t c);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        in_valid <= 1'b1;
        in_item  <= c;
        do @(posedge clk); while (!in_ready);
        expected_coeffs.push_back(cell_coeffs(c));
    endtask

    // Lowers valid after the last item of a burst and waits for the pipe to empty.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_coeffs.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic run_random_cells(input int count, input int idle, input int stall);
        idle_pct = idle;
        stall_pct <= stall;
        random_config();
        repeat (count) send_cell(random_cell());
        drain();
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        int cc, rc;
        idle_pct = 0;
        stall_pct <= 0;
        // Registers at their reset values.
        send_cell(make_cell(2'd0, 2'd0, K_ONE, 31'(2 * K_ONE), 31'(3 * K_ONE),
                            31'(4 * K_ONE), 31'(5 * K_ONE), 32'h0001_8000));
        drain();
        load_config(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0002_0000,
                    32'hFFFD_0000, 32'h0001_8000, 32'hFFFF_4000);
        // Every column and row class, the unused class code included.
        for (cc = 0; cc < 4; cc++)
            for (rc = 0; rc < 4; rc++)
                send_cell(make_cell(cc[1:0], rc[1:0], K_ONE, 31'(2 * K_ONE),
                                    31'(3 * K_ONE), 31'(4 * K_ONE), 31'(5 * K_ONE),
                                    32'h0000_C000));
        drain();
        // A write to an index past the register list must change nothing.
        write_reg(CFG_UNUSED, 32'hDEAD_BEEF);
        load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_cell(make_cell(2'd0, 2'd0, K_MAX, K_MAX, K_MAX, K_MAX, K_MAX, 32'h7FFF_FFFF));
        send_cell(make_cell(COL_LEFT, ROW_TOP, K_MAX, '0, K_MAX, K_MAX, '0,
                            32'h7FFF_FFFF));
        send_cell(make_cell(COL_RIGHT, ROW_BOTTOM, '0, '0, '0, '0, '0, 32'h7FFF_FFFF));
        send_cell(make_cell(2'd3, 2'd3, K_MAX, K_MAX, '0, K_MAX, '0, 32'h8000_0000));
        drain();
        load_config(32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_cell(make_cell(COL_LEFT, ROW_BOTTOM, K_MAX, K_MAX, K_MAX, K_MAX, K_MAX,
                            32'h8000_0000));
        send_cell(make_cell(COL_RIGHT, ROW_TOP, K_MAX, K_MAX, K_MAX, K_MAX, K_MAX,
                            32'h0000_0000));
        send_cell(make_cell(2'd0, 2'd0, '0, '0, '0, '0, '0, 32'h8000_0000));
        drain();
    endtask

    task automatic test_streaming();
        run_random_cells(420, 0, 0);
    endtask

    task automatic test_sender_gaps();
        run_random_cells(420, 61, 0);
    endtask

    task automatic test_receiver_stalls();
        run_random_cells(420, 0, 61);
    endtask

    task automatic test_gaps_and_stalls();
        run_random_cells(420, 36, 36);
    endtask

    // A long output hold fills the pipe while cells keep coming, then the
    // sender pauses until everything is out before a second, gappy burst.
    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct <= 0;
        random_config();
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        repeat (100) send_cell(random_cell());
        drain();
        idle_pct = 36;
        stall_pct <= 36;
        repeat (100) send_cell(random_cell());
        drain();
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    initial
    begin : result_check
        out_item_t want;
        int        hold_left;
        int        f;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (expected_coeffs.size() == 0)
                    report($sformatf("result %0d arrived with no cell pending: %h",
                                     result_count, out_item));
                else
                begin
                    want = expected_coeffs.pop_front();
                    for (f = 0; f < 6; f++)
                        if (out_item[(5 - f) * 32 +: 32] !== want[(5 - f) * 32 +: 32])
                            report($sformatf("result %0d %s: expected %h, got %h",
                                             result_count, field_name[f],
                                             want[(5 - f) * 32 +: 32],
                                             out_item[(5 - f) * 32 +: 32]));
                end
                result_count++;
            end
            if (hold_req)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ---------------------------------------------------------------- main

    initial
    begin
        ew_ratio    = K_ONE;
        ns_ratio    = K_ONE;
        sink_term   = '0;
        left_wall   = '0;
        right_wall  = '0;
        top_wall    = '0;
        bottom_flux = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_gaps_and_stalls();
        test_backpressure();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_coeffs.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
